@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/edfs_pkg.sv @@
`timescale 1ns / 1ps

package edfs_pkg;

    localparam logic [1:0] ACT_TICK        = 2'd0;
    localparam logic [1:0] ACT_CREATE_NORM = 2'd1;
    localparam logic [1:0] ACT_CREATE_RT   = 2'd2;
    localparam logic [1:0] ACT_SELECT      = 2'd3;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_NORMAL = 2'd1;
    localparam logic [1:0] KIND_RT     = 2'd2;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic rt_better;
        logic nb_better;
        logic rt_unready;
    } cmp_res_t;

endpackage

@@ sv/edfs_entry_mem.sv @@
`timescale 1ns / 1ps

module edfs_entry_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 68,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/edfs_cmp.sv @@
`timescale 1ns / 1ps

module edfs_cmp #(
    parameter int TIME_BITS = 32,
    parameter int ORD_W     = 4
) (
    input  logic [1:0]           kind,
    input  logic                 queued,
    input  logic [TIME_BITS-1:0] start,
    input  logic [TIME_BITS-1:0] dl,
    input  logic [ORD_W-1:0]     ord,
    input  logic [TIME_BITS-1:0] now,
    input  logic [TIME_BITS-1:0] best_dl,
    input  logic [ORD_W-1:0]     best_ord,
    input  logic                 rt_found,
    input  logic [ORD_W-1:0]     nb_ord,
    input  logic                 nb_found,
    output edfs_pkg::cmp_res_t   res
);
    import edfs_pkg::*;

    logic is_rt;
    logic is_nb;
    logic started;

    assign is_rt   = queued && (kind == KIND_RT);
    assign is_nb   = queued && (kind == KIND_NORMAL);
    assign started = (start <= now);

    always_comb begin
        res.rt_better  = is_rt && started &&
                         (!rt_found || (dl < best_dl) || ((dl == best_dl) && (ord < best_ord)));
        res.nb_better  = is_nb && (!nb_found || (ord < nb_ord));
        res.rt_unready = is_rt && !started;
    end

endmodule

@@ sv/edf_realtime_scheduler.sv @@
`timescale 1ns / 1ps

// Task table scheduler: earliest deadline first for realtime tasks, round-robin
// for normal tasks, with a millisecond clock and met and miss counters.
// The input channel (s_) carries one command per transaction: the action in
// s_tuser, the realtime start, relative deadline and finished flag in s_tdata.
// Every command gives exactly one result transaction on the m_ channel.
// A creation scans the slot kinds one per cycle. A select reads the task memory
// once per slot, and when the running task changes sweeps the memory once more
// to close the queue ranks. The task memory has separate read and write ports,
// and one compare unit is shared by all slots. One command is worked on at a
// time, and s_tready is low meanwhile.
// The result sits in an output register; the next command is accepted while
// it waits, and a stalled receiver holds back only the following result.
// After reset all slots are free, the clock and both counters are zero and no
// task runs.
module edf_realtime_scheduler #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_ms[31:0], relative_deadline_ms[63:32], current_finished[64], zero fill
    input  logic [edfs_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [edfs_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // selected_slot[3:0], selected_valid[4], waiting_for_start[5], created_slot[9:6],
    // create_ok[10], met_count[26:11], miss_count[42:27], clock_ms[74:43], zero fill
    output logic [edfs_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import edfs_pkg::*;

    `include "assert_macros.svh"

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int ORD_W  = SLOT_W;
    localparam int ENT_W  = 2 * TIME_BITS + ORD_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CR_SCAN = 4'd1;
    localparam logic [3:0] ST_CR_WR   = 4'd2;
    localparam logic [3:0] ST_FIN_RD  = 4'd3;
    localparam logic [3:0] ST_FIN_CHK = 4'd4;
    localparam logic [3:0] ST_SCAN    = 4'd5;
    localparam logic [3:0] ST_DECIDE  = 4'd6;
    localparam logic [3:0] ST_SWEEP   = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 rd_v_reg, rd_v_next;
    logic [1:0]           kind_reg [TASK_SLOTS];
    logic [1:0]           kind_next [TASK_SLOTS];
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [COUNT_W-1:0]   met_reg, met_next;
    logic [COUNT_W-1:0]   miss_reg, miss_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    run_slot_reg, run_slot_next;
    logic                 run_valid_reg, run_valid_next;
    logic                 rt_found_reg, rt_found_next;
    logic                 nb_found_reg, nb_found_next;
    logic                 unready_reg, unready_next;
    logic                 enq_r_reg, enq_r_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload state
    logic [SLOT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [1:0]           act_reg, act_next;
    logic [TIME_BITS-1:0] start_in_reg, start_in_next;
    logic [TIME_BITS-1:0] rel_in_reg, rel_in_next;
    logic [TIME_BITS-1:0] best_dl_reg, best_dl_next;
    logic [ORD_W-1:0]     best_ord_reg, best_ord_next;
    logic [SLOT_W-1:0]    best_slot_reg, best_slot_next;
    logic [ORD_W-1:0]     nb_ord_reg, nb_ord_next;
    logic [SLOT_W-1:0]    nb_slot_reg, nb_slot_next;
    logic [TIME_BITS-1:0] run_dl_reg, run_dl_next;
    logic [SLOT_W-1:0]    d_slot_reg, d_slot_next;
    logic [ORD_W-1:0]     d_ord_reg, d_ord_next;
    logic [3:0]           sel_slot_reg, sel_slot_next;
    logic                 sel_valid_reg, sel_valid_next;
    logic                 wait_reg, wait_next;
    logic [3:0]           cr_slot_reg, cr_slot_next;
    logic                 cr_ok_reg, cr_ok_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // Task memory port
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [SLOT_W-1:0]    mem_raddr;
    logic [ENT_W-1:0]     mem_rdata;

    logic [TIME_BITS-1:0] rd_start;
    logic [TIME_BITS-1:0] rd_dl;
    logic [ORD_W-1:0]     rd_ord;
    logic [1:0]           rd_kind;
    logic                 rd_queued;
    cmp_res_t             cmp_res;

    logic                 run_is_rt;
    logic                 go;
    logic [SLOT_W-1:0]    tgt_slot;
    logic [ORD_W-1:0]     tgt_ord;

    assign rd_start  = mem_rdata[TIME_BITS-1:0];
    assign rd_dl     = mem_rdata[2*TIME_BITS-1:TIME_BITS];
    assign rd_ord    = mem_rdata[ENT_W-1:2*TIME_BITS];
    assign rd_kind   = kind_reg[rd_idx_reg];
    assign rd_queued = ((rd_kind == KIND_NORMAL) || (rd_kind == KIND_RT)) &&
                       !(run_valid_reg && (rd_idx_reg == run_slot_reg));
    assign run_is_rt = (kind_reg[run_slot_reg] == KIND_RT);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    edfs_entry_mem #(
        .DEPTH (TASK_SLOTS),
        .WIDTH (ENT_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    edfs_cmp #(
        .TIME_BITS (TIME_BITS),
        .ORD_W     (ORD_W)
    ) u_cmp (
        .kind     (rd_kind),
        .queued   (rd_queued),
        .start    (rd_start),
        .dl       (rd_dl),
        .ord      (rd_ord),
        .now      (now_reg),
        .best_dl  (best_dl_reg),
        .best_ord (best_ord_reg),
        .rt_found (rt_found_reg),
        .nb_ord   (nb_ord_reg),
        .nb_found (nb_found_reg),
        .res      (cmp_res)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rd_v_next      = 1'b0;
        kind_next      = kind_reg;
        now_next       = now_reg;
        met_next       = met_reg;
        miss_next      = miss_reg;
        cnt_next       = cnt_reg;
        run_slot_next  = run_slot_reg;
        run_valid_next = run_valid_reg;
        rt_found_next  = rt_found_reg;
        nb_found_next  = nb_found_reg;
        unready_next   = unready_reg;
        enq_r_next     = enq_r_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        rd_idx_next    = rd_idx_reg;
        act_next       = act_reg;
        start_in_next  = start_in_reg;
        rel_in_next    = rel_in_reg;
        best_dl_next   = best_dl_reg;
        best_ord_next  = best_ord_reg;
        best_slot_next = best_slot_reg;
        nb_ord_next    = nb_ord_reg;
        nb_slot_next   = nb_slot_reg;
        run_dl_next    = run_dl_reg;
        d_slot_next    = d_slot_reg;
        d_ord_next     = d_ord_reg;
        sel_slot_next  = sel_slot_reg;
        sel_valid_next = sel_valid_reg;
        wait_next      = wait_reg;
        cr_slot_next   = cr_slot_reg;
        cr_ok_next     = cr_ok_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = rd_idx_reg;
        mem_wdata      = {rd_ord, rd_dl, rd_start};
        mem_raddr      = idx_reg[SLOT_W-1:0];
        go             = 1'b0;
        tgt_slot       = best_slot_reg;
        tgt_ord        = best_ord_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next       = s_tuser[1:0];
                    start_in_next  = TIME_BITS'(s_tdata[31:0]);
                    rel_in_next    = TIME_BITS'(s_tdata[63:32]);
                    sel_slot_next  = 4'd0;
                    sel_valid_next = 1'b0;
                    wait_next      = 1'b0;
                    cr_slot_next   = 4'd0;
                    cr_ok_next     = 1'b0;
                    idx_next       = '0;
                    rt_found_next  = 1'b0;
                    nb_found_next  = 1'b0;
                    unready_next   = 1'b0;
                    unique case (s_tuser[1:0])
                        ACT_TICK: begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_DONE;
                        end
                        ACT_CREATE_NORM, ACT_CREATE_RT: begin
                            state_next = ST_CR_SCAN;
                        end
                        default: begin
                            if (s_tdata[64] && run_valid_reg) begin
                                state_next = ST_FIN_RD;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_CR_SCAN: begin
                if (idx_reg == SLOTS_CNT) begin
                    state_next = ST_DONE;
                end else if ((kind_reg[idx_reg[SLOT_W-1:0]] != KIND_NORMAL) &&
                             (kind_reg[idx_reg[SLOT_W-1:0]] != KIND_RT)) begin
                    state_next = ST_CR_WR;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_CR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[SLOT_W-1:0];
                if (act_reg == ACT_CREATE_RT) begin
                    mem_wdata = {cnt_reg[ORD_W-1:0], start_in_reg + rel_in_reg, start_in_reg};
                    kind_next[idx_reg[SLOT_W-1:0]] = KIND_RT;
                end else begin
                    mem_wdata = {cnt_reg[ORD_W-1:0], {(2*TIME_BITS){1'b0}}};
                    kind_next[idx_reg[SLOT_W-1:0]] = KIND_NORMAL;
                end
                cnt_next     = cnt_reg + 1'b1;
                cr_slot_next = 4'(idx_reg[SLOT_W-1:0]);
                cr_ok_next   = 1'b1;
                state_next   = ST_DONE;
            end

            ST_FIN_RD: begin
                mem_raddr  = run_slot_reg;
                state_next = ST_FIN_CHK;
            end

            ST_FIN_CHK: begin
                // Realtime work counts once: late if the clock has passed the deadline.
                if (run_is_rt) begin
                    if (now_reg > rd_dl) begin
                        if (miss_reg != COUNT_MAX) begin
                            miss_next = miss_reg + 1'b1;
                        end
                    end else if (met_reg != COUNT_MAX) begin
                        met_next = met_reg + 1'b1;
                    end
                end
                kind_next[run_slot_reg] = KIND_FREE;
                run_valid_next          = 1'b0;
                state_next              = ST_SCAN;
            end

            ST_SCAN: begin
                if (idx_reg != SLOTS_CNT) begin
                    rd_v_next   = 1'b1;
                    rd_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (rd_v_reg) begin
                    if (cmp_res.rt_better) begin
                        best_dl_next   = rd_dl;
                        best_ord_next  = rd_ord;
                        best_slot_next = rd_idx_reg;
                        rt_found_next  = 1'b1;
                    end
                    if (cmp_res.nb_better) begin
                        nb_ord_next   = rd_ord;
                        nb_slot_next  = rd_idx_reg;
                        nb_found_next = 1'b1;
                    end
                    if (cmp_res.rt_unready) begin
                        unready_next = 1'b1;
                    end
                    if (run_valid_reg && (rd_idx_reg == run_slot_reg)) begin
                        run_dl_next = rd_dl;
                    end
                end
                if ((idx_reg == SLOTS_CNT) && !rd_v_reg) begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (run_valid_reg) begin
                    if (run_is_rt) begin
                        go = rt_found_reg && (run_dl_reg > best_dl_reg);
                    end else if (rt_found_reg) begin
                        go = 1'b1;
                    end else if (nb_found_reg) begin
                        go       = 1'b1;
                        tgt_slot = nb_slot_reg;
                        tgt_ord  = nb_ord_reg;
                    end
                end else if (rt_found_reg) begin
                    go = 1'b1;
                end else if (nb_found_reg) begin
                    go       = 1'b1;
                    tgt_slot = nb_slot_reg;
                    tgt_ord  = nb_ord_reg;
                end else begin
                    wait_next = unready_reg;
                end
                if (go) begin
                    d_slot_next = tgt_slot;
                    d_ord_next  = tgt_ord;
                    enq_r_next  = run_valid_reg;
                    idx_next    = '0;
                    state_next  = ST_SWEEP;
                end else begin
                    sel_slot_next  = run_valid_reg ? 4'(run_slot_reg) : 4'd0;
                    sel_valid_next = run_valid_reg;
                    state_next     = ST_DONE;
                end
            end

            ST_SWEEP: begin
                // The chosen task leaves the queue: later ranks move up by one,
                // and a preempted task takes the tail rank.
                if (idx_reg != SLOTS_CNT) begin
                    rd_v_next   = 1'b1;
                    rd_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (rd_v_reg) begin
                    if (enq_r_reg && (rd_idx_reg == run_slot_reg)) begin
                        mem_we    = 1'b1;
                        mem_wdata = {ORD_W'(cnt_reg - 1'b1), rd_dl, rd_start};
                    end else if (rd_queued && (rd_idx_reg != d_slot_reg) &&
                                 (rd_ord > d_ord_reg)) begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_ord - 1'b1, rd_dl, rd_start};
                    end
                end
                if ((idx_reg == SLOTS_CNT) && !rd_v_reg) begin
                    run_slot_next  = d_slot_reg;
                    run_valid_next = 1'b1;
                    if (!enq_r_reg) begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    sel_slot_next  = 4'(d_slot_reg);
                    sel_valid_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, 32'(now_reg), miss_reg, met_reg, cr_ok_reg,
                                    cr_slot_reg, wait_reg, sel_valid_reg, sel_slot_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rd_v_reg      <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                kind_reg[i] <= KIND_FREE;
            end
            now_reg       <= '0;
            met_reg       <= '0;
            miss_reg      <= '0;
            cnt_reg       <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            rt_found_reg  <= 1'b0;
            nb_found_reg  <= 1'b0;
            unready_reg   <= 1'b0;
            enq_r_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rd_v_reg      <= rd_v_next;
            kind_reg      <= kind_next;
            now_reg       <= now_next;
            met_reg       <= met_next;
            miss_reg      <= miss_next;
            cnt_reg       <= cnt_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            rt_found_reg  <= rt_found_next;
            nb_found_reg  <= nb_found_next;
            unready_reg   <= unready_next;
            enq_r_reg     <= enq_r_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        act_reg       <= act_next;
        start_in_reg  <= start_in_next;
        rel_in_reg    <= rel_in_next;
        best_dl_reg   <= best_dl_next;
        best_ord_reg  <= best_ord_next;
        best_slot_reg <= best_slot_next;
        nb_ord_reg    <= nb_ord_next;
        nb_slot_reg   <= nb_slot_next;
        run_dl_reg    <= run_dl_next;
        d_slot_reg    <= d_slot_next;
        d_ord_reg     <= d_ord_next;
        sel_slot_reg  <= sel_slot_next;
        sel_valid_reg <= sel_valid_next;
        wait_reg      <= wait_next;
        cr_slot_reg   <= cr_slot_next;
        cr_ok_reg     <= cr_ok_next;
        m_data_reg    <= m_data_next;
    end

    `ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= SLOTS_CNT, "queue count exceeds slots")
    `ASSERT_IMPLIES(a_run_occupied, aclk, aresetn, run_valid_reg,
        (kind_reg[run_slot_reg] == KIND_NORMAL) || (kind_reg[run_slot_reg] == KIND_RT),
        "running slot is free")
    `ASSERT_IMPLIES(a_met_mono, aclk, aresetn, $past(aresetn), met_reg >= $past(met_reg),
        "met counter decreased")
    `ASSERT_IMPLIES(a_miss_mono, aclk, aresetn, $past(aresetn), miss_reg >= $past(miss_reg),
        "miss counter decreased")

endmodule
